// ===== sv/sccp_pkg.sv =====
package sccp_pkg;

    localparam int COORD_BITS_DEF = 20;

    // limb width of the split wide multipliers
    localparam int MUL_LIMB = 32;

    localparam int REG_IDX_W   = 3;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 1;

    // input tuser bit positions
    localparam int TU_REMOVED = 0;
    localparam int TU_SHOWN   = 1;
    localparam int TU_TOP     = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_PRIOR_X,
        REG_PRIOR_Y,
        REG_PRIOR_Z,
        REG_RADIUS,
        REG_SHELL
    } t_reg_idx;

    typedef struct packed {
        logic removed;
        logic shown;
        logic top;
        logic sweep;
        logic dot_pos;
    } t_flags;

endpackage

// ===== sv/sccp_mul.sv =====
module sccp_mul import sccp_pkg::*; #(
    parameter int A_W = 8,
    parameter int B_W = 8
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_p
);

    localparam int NA    = (A_W + MUL_LIMB - 1) / MUL_LIMB;
    localparam int NB    = (B_W + MUL_LIMB - 1) / MUL_LIMB;
    localparam int SUM_W = (NA + NB) * MUL_LIMB;

    logic [NA*MUL_LIMB-1:0] a_pad;
    logic [NB*MUL_LIMB-1:0] b_pad;
    logic [2*MUL_LIMB-1:0]  n_pp [NA][NB];
    logic [2*MUL_LIMB-1:0]  r_pp [NA][NB];
    logic [SUM_W-1:0]       n_sum;
    logic [A_W+B_W-1:0]     r_p;

    assign a_pad = (NA*MUL_LIMB)'(i_a);
    assign b_pad = (NB*MUL_LIMB)'(i_b);

    // limb by limb partial products, registered in r_pp
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_pp[i][j] = (2*MUL_LIMB)'(a_pad[i*MUL_LIMB +: MUL_LIMB])
                           * (2*MUL_LIMB)'(b_pad[j*MUL_LIMB +: MUL_LIMB]);
            end
        end
    end

    // shifted sum of the registered partials, registered in r_p
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_sum = n_sum + (SUM_W'(r_pp[i][j]) << ((i + j) * MUL_LIMB));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp <= n_pp;
            r_p  <= n_sum[A_W+B_W-1:0];
        end
    end

    assign o_p = r_p;

endmodule

// ===== sv/sphere_cut_point_classifier_core.sv =====
// channel   dir  beat contents
// s_axis    in   tdata: point_x, point_y, point_z; tuser: removed_in, shown_in, top_layer
// m_axis    out  tdata: removed_out; tuser: shown_out
// cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data, one register per write
//
// one beat per cycle sustained while the output is not stalled
// the datapath has eight stages; two of them are the split wide multipliers
// reset clears the stage valid bits and the configuration registers to zero, no clearing pass
// a stalled output beat freezes every stage, s_axis_tready drops in the same cycle
module sphere_cut_point_classifier_core import sccp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [REG_IDX_W-1:0]                   i_cfg_idx,
    input  logic [COORD_BITS-1:0]                  i_cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // point_x, point_y, point_z, zero fill
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // removed_in, shown_in, top_layer
    input  logic [IN_TUSER_W-1:0]                  s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // removed_out, zero fill
    output logic [OUT_TDATA_W-1:0]                 m_axis_tdata,
    // shown_out
    output logic [OUT_TUSER_W-1:0]                 m_axis_tuser
);

    localparam int C      = COORD_BITS;
    localparam int DW     = C + 1;          // signed difference
    localparam int PW     = 2*C + 2;        // signed product of two differences
    localparam int SW     = 2*C;            // one square
    localparam int SQW    = 2*C + 2;        // sum of three squares
    localparam int DTW    = 2*C + 3;        // signed dot product
    localparam int CAW    = 2*C + 1;        // cross component magnitude
    localparam int RW     = C - 1;
    localparam int RRW    = 2*C - 2;
    localparam int P_DOT2 = 2*SQW;
    localparam int P_MMDD = 2*SQW;
    localparam int P_CX   = 2*CAW;
    localparam int P_RRMM = RRW + SQW;
    localparam int CRSW   = P_CX + 2;
    localparam int LHSW   = P_DOT2 + 2;

    logic                 en;

    logic [C-1:0]         r_center [3];
    logic [C-1:0]         r_prior [3];
    logic [RW-1:0]        r_radius;
    logic [RW-1:0]        r_shell;

    logic signed [C-1:0]  pt [3];

    // stage 1: differences
    logic                 r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v, r_s7_v, r_s8_v;
    logic signed [DW-1:0] n_s1_d [3], n_s1_m [3], r_s1_d [3], r_s1_m [3];
    t_flags               n_s1_f, r_s1_f;

    // stage 2: narrow products
    logic signed [PW-1:0] pdd [3], pmm [3];
    logic [SW-1:0]        n_s2_sqd [3], n_s2_sqm [3], r_s2_sqd [3], r_s2_sqm [3];
    logic signed [PW-1:0] n_s2_dm [3], r_s2_dm [3];
    logic signed [PW-1:0] n_s2_xp [6], r_s2_xp [6];
    logic [RRW-1:0]       n_s2_rr, n_s2_ss, r_s2_rr, r_s2_ss;
    t_flags               r_s2_f;

    // stage 3: sums
    logic [SQW-1:0]       n_s3_dd, n_s3_mm, r_s3_dd, r_s3_mm;
    logic signed [DTW-1:0] n_s3_dot, r_s3_dot;
    logic signed [PW-1:0] n_s3_c [3], r_s3_c [3];
    logic [RRW-1:0]       r_s3_rr, r_s3_ss;
    t_flags               r_s3_f;

    // stage 4: sphere test, magnitudes
    t_flags               n_s4_f, r_s4_f;
    logic [SQW-1:0]       n_s4_adot, r_s4_adot;
    logic [CAW-1:0]       n_s4_ac [3], r_s4_ac [3];
    logic [SQW-1:0]       r_s4_dd, r_s4_mm;
    logic [RRW-1:0]       r_s4_rr, r_s4_ss;

    // stages 5 and 6: wide products
    t_flags               r_s5_f, r_s6_f;
    logic [P_DOT2-1:0]    p_dot2;
    logic [P_MMDD-1:0]    p_mmdd;
    logic [P_CX-1:0]      p_c2 [3];
    logic [P_RRMM-1:0]    p_rrmm, p_ssmm;

    // stage 7: angle test, perpendicular sum
    t_flags               n_s7_f, r_s7_f;
    logic [LHSW-1:0]      lhs;
    logic [CRSW-1:0]      n_s7_cr, r_s7_cr;
    logic [P_RRMM-1:0]    r_s7_rrmm, r_s7_ssmm;

    // stage 8: output register
    logic                 n_s8_removed, n_s8_shown, r_s8_removed, r_s8_shown;

    assign en            = !r_s8_v || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_center[i] <= '0;
                r_prior[i]  <= '0;
            end
            r_radius <= '0;
            r_shell  <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_CENTER_X: r_center[0] <= i_cfg_data;
                REG_CENTER_Y: r_center[1] <= i_cfg_data;
                REG_CENTER_Z: r_center[2] <= i_cfg_data;
                REG_PRIOR_X:  r_prior[0]  <= i_cfg_data;
                REG_PRIOR_Y:  r_prior[1]  <= i_cfg_data;
                REG_PRIOR_Z:  r_prior[2]  <= i_cfg_data;
                REG_RADIUS:   r_radius    <= i_cfg_data[RW-1:0];
                REG_SHELL:    r_shell     <= i_cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pt[i]     = s_axis_tdata[i*C +: C];
            n_s1_d[i] = {pt[i][C-1], pt[i]} - {r_center[i][C-1], r_center[i]};
            n_s1_m[i] = {r_center[i][C-1], r_center[i]} - {r_prior[i][C-1], r_prior[i]};
        end
        n_s1_f.removed = s_axis_tuser[TU_REMOVED];
        n_s1_f.shown   = s_axis_tuser[TU_SHOWN];
        n_s1_f.top     = s_axis_tuser[TU_TOP];
        // sweep stays possible only with a prior center off the origin
        n_s1_f.sweep   = (r_prior[0] != '0) || (r_prior[1] != '0) || (r_prior[2] != '0);
        n_s1_f.dot_pos = 1'b0;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pdd[i]      = r_s1_d[i] * r_s1_d[i];
            pmm[i]      = r_s1_m[i] * r_s1_m[i];
            n_s2_sqd[i] = pdd[i][SW-1:0];
            n_s2_sqm[i] = pmm[i][SW-1:0];
            n_s2_dm[i]  = r_s1_d[i] * r_s1_m[i];
        end
        n_s2_xp[0] = r_s1_d[1] * r_s1_m[2];
        n_s2_xp[1] = r_s1_d[2] * r_s1_m[1];
        n_s2_xp[2] = r_s1_d[2] * r_s1_m[0];
        n_s2_xp[3] = r_s1_d[0] * r_s1_m[2];
        n_s2_xp[4] = r_s1_d[0] * r_s1_m[1];
        n_s2_xp[5] = r_s1_d[1] * r_s1_m[0];
        n_s2_rr    = RRW'(r_radius) * RRW'(r_radius);
        n_s2_ss    = RRW'(r_shell) * RRW'(r_shell);
    end

    always_comb begin
        n_s3_dd  = SQW'(r_s2_sqd[0]) + SQW'(r_s2_sqd[1]) + SQW'(r_s2_sqd[2]);
        n_s3_mm  = SQW'(r_s2_sqm[0]) + SQW'(r_s2_sqm[1]) + SQW'(r_s2_sqm[2]);
        n_s3_dot = DTW'(r_s2_dm[0]) + DTW'(r_s2_dm[1]) + DTW'(r_s2_dm[2]);
        n_s3_c[0] = r_s2_xp[0] - r_s2_xp[1];
        n_s3_c[1] = r_s2_xp[2] - r_s2_xp[3];
        n_s3_c[2] = r_s2_xp[4] - r_s2_xp[5];
    end

    always_comb begin
        n_s4_f = r_s3_f;
        if (r_s3_dd < SQW'(r_s3_rr)) begin
            n_s4_f.removed = 1'b1;
            n_s4_f.shown   = 1'b0;
        end else if ((r_s3_dd <= SQW'(r_s3_ss)) || r_s3_f.top) begin
            n_s4_f.shown = 1'b1;
        end
        // point removed, at the center, beyond the move or no move: no sweep test
        n_s4_f.sweep = r_s3_f.sweep && !n_s4_f.removed && (r_s3_mm != '0)
                       && (r_s3_dd != '0) && (r_s3_dd <= r_s3_mm);
        n_s4_f.dot_pos = !r_s3_dot[DTW-1] && (r_s3_dot != '0);
        n_s4_adot = r_s3_dot[DTW-1] ? SQW'(-r_s3_dot) : SQW'(r_s3_dot);
        for (int i = 0; i < 3; i++) begin
            n_s4_ac[i] = r_s3_c[i][PW-1] ? CAW'(-r_s3_c[i]) : CAW'(r_s3_c[i]);
        end
    end

    sccp_mul #(.A_W(SQW), .B_W(SQW)) u_mul_dot2 (
        .i_clk (i_clk), .i_en (en), .i_a (r_s4_adot), .i_b (r_s4_adot), .o_p (p_dot2)
    );

    sccp_mul #(.A_W(SQW), .B_W(SQW)) u_mul_mmdd (
        .i_clk (i_clk), .i_en (en), .i_a (r_s4_mm), .i_b (r_s4_dd), .o_p (p_mmdd)
    );

    sccp_mul #(.A_W(RRW), .B_W(SQW)) u_mul_rrmm (
        .i_clk (i_clk), .i_en (en), .i_a (r_s4_rr), .i_b (r_s4_mm), .o_p (p_rrmm)
    );

    sccp_mul #(.A_W(RRW), .B_W(SQW)) u_mul_ssmm (
        .i_clk (i_clk), .i_en (en), .i_a (r_s4_ss), .i_b (r_s4_mm), .o_p (p_ssmm)
    );

    for (genvar g = 0; g < 3; g++) begin : g_cross
        sccp_mul #(.A_W(CAW), .B_W(CAW)) u_mul_c2 (
            .i_clk (i_clk), .i_en (en), .i_a (r_s4_ac[g]), .i_b (r_s4_ac[g]), .o_p (p_c2[g])
        );
    end

    always_comb begin
        // cos <= 0.5 as 4 (d.m)^2 <= (m.m)(d.d) when d.m is positive
        lhs     = {p_dot2, 2'b00};
        n_s7_f  = r_s6_f;
        n_s7_f.sweep = r_s6_f.sweep && (!r_s6_f.dot_pos || (lhs <= LHSW'(p_mmdd)));
        n_s7_cr = CRSW'(p_c2[0]) + CRSW'(p_c2[1]) + CRSW'(p_c2[2]);
    end

    always_comb begin
        n_s8_removed = r_s7_f.removed;
        n_s8_shown   = r_s7_f.shown;
        if (r_s7_f.sweep) begin
            if (r_s7_cr < CRSW'(r_s7_rrmm)) begin
                n_s8_removed = 1'b1;
                n_s8_shown   = 1'b0;
            end else if ((r_s7_cr <= CRSW'(r_s7_ssmm)) || r_s7_f.top) begin
                n_s8_shown = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
            r_s8_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= s_axis_tvalid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            r_s7_v <= r_s6_v;
            r_s8_v <= r_s7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_d    <= n_s1_d;
            r_s1_m    <= n_s1_m;
            r_s1_f    <= n_s1_f;

            r_s2_sqd  <= n_s2_sqd;
            r_s2_sqm  <= n_s2_sqm;
            r_s2_dm   <= n_s2_dm;
            r_s2_xp   <= n_s2_xp;
            r_s2_rr   <= n_s2_rr;
            r_s2_ss   <= n_s2_ss;
            r_s2_f    <= r_s1_f;

            r_s3_dd   <= n_s3_dd;
            r_s3_mm   <= n_s3_mm;
            r_s3_dot  <= n_s3_dot;
            r_s3_c    <= n_s3_c;
            r_s3_rr   <= r_s2_rr;
            r_s3_ss   <= r_s2_ss;
            r_s3_f    <= r_s2_f;

            r_s4_f    <= n_s4_f;
            r_s4_adot <= n_s4_adot;
            r_s4_ac   <= n_s4_ac;
            r_s4_dd   <= r_s3_dd;
            r_s4_mm   <= r_s3_mm;
            r_s4_rr   <= r_s3_rr;
            r_s4_ss   <= r_s3_ss;

            r_s5_f    <= r_s4_f;
            r_s6_f    <= r_s5_f;

            r_s7_f    <= n_s7_f;
            r_s7_cr   <= n_s7_cr;
            r_s7_rrmm <= p_rrmm;
            r_s7_ssmm <= p_ssmm;

            r_s8_removed <= n_s8_removed;
            r_s8_shown   <= n_s8_shown;
        end
    end

    assign m_axis_tvalid = r_s8_v;
    assign m_axis_tdata  = OUT_TDATA_W'(r_s8_removed);
    assign m_axis_tuser  = OUT_TUSER_W'(r_s8_shown);

endmodule

// ===== sv/sccp_checker.sv =====
module sccp_checker import sccp_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    // nothing comes out right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat right after reset");

    // a held output beat must hold back the input side
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    a_tdata_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:1] == '0)
        else $error("fill bits of output tdata not zero");

endmodule

bind sphere_cut_point_classifier_core sccp_checker u_sccp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
